// ----- sv/assert_macros.svh -----
// assertion macros for the rtl, included by traffic_light_sequencer.sv
// depends on nothing; users must provide clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property check on the rising clock edge, disabled while in reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression that must never be true at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_PROP(label, !(expr), msg)

`endif

// ----- sv/tls_pkg.sv -----
// types, codes and constants of the traffic light sequencer
// no dependencies; used by the top level and the testbench
package tls_pkg;

    localparam int TIME_W  = 48;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int THR_W   = 26;
    localparam int US_PER_MS = 1000;

    // event codes
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_NIGHT = 2'd2
    } tls_kind_t;

    // phase codes
    typedef enum logic [2:0] {
        PH_GREEN       = 3'd0,
        PH_GREEN_BLINK = 3'd1,
        PH_YELLOW      = 3'd2,
        PH_RED         = 3'd3,
        PH_RED_YELLOW  = 3'd4,
        PH_NIGHT       = 3'd5
    } tls_phase_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN       = 3'd0,
        CFG_GREEN_FLASH = 3'd1,
        CFG_YELLOW      = 3'd2,
        CFG_RED         = 3'd3,
        CFG_RED_AMBER   = 3'd4,
        CFG_GREEN_HALF  = 3'd5,
        CFG_NIGHT_HALF  = 3'd6
    } tls_cfg_idx_t;

    // lamp bit positions
    localparam int LAMP_G = 0;
    localparam int LAMP_Y = 1;
    localparam int LAMP_R = 2;

    typedef logic [2:0]        tls_lamps_t;
    typedef logic [TIME_W-1:0] tls_time_t;
    typedef logic [THR_W-1:0]  tls_thr_t;

    // reset thresholds in microseconds
    localparam tls_thr_t GREEN_RST_US       = THR_W'(5000 * US_PER_MS);
    localparam tls_thr_t GREEN_FLASH_RST_US = THR_W'(3000 * US_PER_MS);
    localparam tls_thr_t YELLOW_RST_US      = THR_W'(2000 * US_PER_MS);
    localparam tls_thr_t RED_RST_US         = THR_W'(5000 * US_PER_MS);
    localparam tls_thr_t RED_AMBER_RST_US   = THR_W'(1000 * US_PER_MS);
    localparam tls_thr_t GREEN_HALF_RST_US  = THR_W'(500 * US_PER_MS);
    localparam tls_thr_t NIGHT_HALF_RST_US  = THR_W'(500 * US_PER_MS);

    // input event
    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] now_us;
    } tls_event_t;

    // result item
    typedef struct packed {
        logic [2:0] phase;
        logic       green_lamp;
        logic       yellow_lamp;
        logic       red_lamp;
        logic       night_active;
    } tls_result_t;

    // lamps lit on entry to a phase
    function automatic tls_lamps_t phase_lamps(tls_phase_t ph);
        tls_lamps_t l;
        l = '0;
        case (ph)
            PH_GREEN:       l[LAMP_G] = 1'b1;
            PH_GREEN_BLINK: l[LAMP_G] = 1'b1;
            PH_YELLOW:      l[LAMP_Y] = 1'b1;
            PH_RED:         l[LAMP_R] = 1'b1;
            PH_RED_YELLOW:
            begin
                l[LAMP_R] = 1'b1;
                l[LAMP_Y] = 1'b1;
            end
            PH_NIGHT:       l[LAMP_Y] = 1'b1;
            default:        l = '0;
        endcase
        return l;
    endfunction

endpackage

// ----- sv/tls_stream_if.sv -----
// valid/ready stream channel carrying one payload item per transfer
// payload type is set per instance, normally from tls_pkg
interface tls_stream_if #(
    parameter type item_t = logic
) ();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/traffic_light_sequencer.sv -----
// Traffic light sequencer: takes one timestamped event per cycle unless the result
// register stalls, and returns one result per event via input and result registers.
// Phase durations are held as microsecond thresholds computed when a register is
// written, so each event needs only two 48-bit subtracts and compares against the
// stored phase start and blink times; the next state is computed combinationally.
// The result register lets a new event be taken while a finished result waits.
// Depends on tls_pkg, tls_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module traffic_light_sequencer
    import tls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    tls_stream_if.sink           events,
    tls_stream_if.source         results
);

    // configuration thresholds in microseconds
    tls_thr_t green_us_reg, green_flash_us_reg, yellow_us_reg, red_us_reg;
    tls_thr_t red_amber_us_reg, green_half_us_reg, night_half_us_reg;
    tls_thr_t cfg_us;

    // pipeline registers
    logic        s1_valid_reg;
    tls_event_t  s1_item_reg;
    logic        out_valid_reg;
    tls_result_t out_item_reg;
    logic        out_free;
    logic        advance;

    // sequencer state
    tls_phase_t  phase_reg, phase_next;
    logic        night_reg, night_next;
    tls_time_t   start_reg, start_next;
    tls_time_t   toggle_reg, toggle_next;
    tls_lamps_t  lamp_reg, lamp_next;
    tls_result_t result_next;

    // tick evaluation
    tls_time_t   now_us;
    tls_time_t   start_diff, toggle_diff;
    tls_thr_t    dur_us, half_us;
    logic        dur_done, half_done;
    logic        enter;
    tls_phase_t  enter_phase;

    // config write: scale milliseconds to microseconds once
    assign cfg_us = THR_W'(cfg_data) * THR_W'(US_PER_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_us_reg       <= GREEN_RST_US;
            green_flash_us_reg <= GREEN_FLASH_RST_US;
            yellow_us_reg      <= YELLOW_RST_US;
            red_us_reg         <= RED_RST_US;
            red_amber_us_reg   <= RED_AMBER_RST_US;
            green_half_us_reg  <= GREEN_HALF_RST_US;
            night_half_us_reg  <= NIGHT_HALF_RST_US;
        end
        else if (cfg_we)
        begin
            case (tls_cfg_idx_t'(cfg_index))
                CFG_GREEN:       green_us_reg       <= cfg_us;
                CFG_GREEN_FLASH: green_flash_us_reg <= cfg_us;
                CFG_YELLOW:      yellow_us_reg      <= cfg_us;
                CFG_RED:         red_us_reg         <= cfg_us;
                CFG_RED_AMBER:   red_amber_us_reg   <= cfg_us;
                CFG_GREEN_HALF:  green_half_us_reg  <= cfg_us;
                CFG_NIGHT_HALF:  night_half_us_reg  <= cfg_us;
                default:         ;
            endcase
        end
    end

    // flow control: input stage moves when the result register is free
    assign out_free     = !out_valid_reg || results.ready;
    assign advance      = s1_valid_reg && out_free;
    assign events.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            s1_valid_reg <= events.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.ready && events.valid)
        begin
            s1_item_reg <= events.payload;
        end
    end

    // elapsed times and thresholds for the current phase
    assign now_us      = s1_item_reg.now_us;
    assign start_diff  = now_us - start_reg;
    assign toggle_diff = now_us - toggle_reg;

    always_comb
    begin
        case (phase_reg)
            PH_GREEN:       dur_us = green_us_reg;
            PH_GREEN_BLINK: dur_us = green_flash_us_reg;
            PH_YELLOW:      dur_us = yellow_us_reg;
            PH_RED:         dur_us = red_us_reg;
            PH_RED_YELLOW:  dur_us = red_amber_us_reg;
            default:        dur_us = '0;
        endcase
        half_us = (phase_reg == PH_NIGHT) ? night_half_us_reg : green_half_us_reg;
    end

    assign dur_done  = start_diff >= TIME_W'(dur_us);
    assign half_done = toggle_diff >= TIME_W'(half_us);

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        night_next  = night_reg;
        start_next  = start_reg;
        toggle_next = toggle_reg;
        lamp_next   = lamp_reg;
        enter       = 1'b0;
        enter_phase = PH_RED;
        case (tls_kind_t'(s1_item_reg.kind))
            KIND_TICK:
            begin
                case (phase_reg)
                    PH_GREEN:
                    begin
                        enter       = dur_done;
                        enter_phase = PH_GREEN_BLINK;
                    end
                    PH_GREEN_BLINK:
                    begin
                        if (half_done)
                        begin
                            lamp_next[LAMP_G] = !lamp_reg[LAMP_G];
                            toggle_next       = now_us;
                        end
                        enter       = dur_done;
                        enter_phase = PH_YELLOW;
                    end
                    PH_YELLOW:
                    begin
                        enter       = dur_done;
                        enter_phase = PH_RED;
                    end
                    PH_RED:
                    begin
                        enter       = dur_done;
                        enter_phase = PH_RED_YELLOW;
                    end
                    PH_RED_YELLOW:
                    begin
                        enter       = dur_done;
                        enter_phase = PH_GREEN;
                    end
                    PH_NIGHT:
                    begin
                        if (half_done)
                        begin
                            lamp_next[LAMP_Y] = !lamp_reg[LAMP_Y];
                            toggle_next       = now_us;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_START:
            begin
                enter       = 1'b1;
                enter_phase = PH_RED;
            end
            KIND_NIGHT:
            begin
                enter       = 1'b1;
                night_next  = !night_reg;
                enter_phase = night_reg ? PH_RED : PH_NIGHT;
            end
            default: ;
        endcase
        if (enter)
        begin
            phase_next  = enter_phase;
            start_next  = now_us;
            toggle_next = now_us;
            lamp_next   = phase_lamps(enter_phase);
        end
    end

    // result fields reflect the state after the event
    always_comb
    begin
        result_next.phase        = phase_next;
        result_next.green_lamp   = lamp_next[LAMP_G];
        result_next.yellow_lamp  = lamp_next[LAMP_Y];
        result_next.red_lamp     = lamp_next[LAMP_R];
        result_next.night_active = night_next;
    end

    // state update on each processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RED;
            night_reg  <= 1'b0;
            start_reg  <= '0;
            toggle_reg <= '0;
            lamp_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            night_reg  <= night_next;
            start_reg  <= start_next;
            toggle_reg <= toggle_next;
            lamp_reg   <= lamp_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_item_reg;

    // checks
    `ASSERT_PROP(a_start_enters_red,
        advance && s1_item_reg.kind == KIND_START |=> phase_reg == PH_RED,
        "start event did not enter red")
    `ASSERT_PROP(a_night_flag_flips,
        advance && s1_item_reg.kind == KIND_NIGHT |=> night_reg != $past(night_reg),
        "night event did not flip the night flag")
    `ASSERT_NEVER(a_no_green_with_red,
        lamp_reg[LAMP_G] && lamp_reg[LAMP_R],
        "green and red lamps lit together")
    `ASSERT_PROP(a_stalled_event_held,
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_item_reg),
        "stalled event lost from input register")
    `ASSERT_PROP(a_result_follows_event,
        advance |=> out_valid_reg,
        "processed event produced no result")

endmodule

// ----- tb/sv/traffic_light_sequencer_tb.sv -----
// self-checking testbench for traffic_light_sequencer: timed events in, lamp states out
// a scoreboard class predicts phase and lamps per event and checks each result in order
// depends on tls_pkg, tls_stream_if and the traffic_light_sequencer rtl
module traffic_light_sequencer_tb;
    import tls_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int NUM_PHASES = 8;
    localparam int REPORT_LIMIT = 10;

    // lamp state predictor and store of expected results
    class lamp_tracker;
        logic [CFG_W-1:0] cfg_ms [7];
        tls_phase_t       cur;
        logic             night;
        tls_time_t        start_us;
        tls_time_t        blink_us;
        tls_lamps_t       lamps;
        tls_result_t      expected_lights [$];
        int unsigned      failures;

        function new();
            cfg_ms[CFG_GREEN]       = 16'd5000;
            cfg_ms[CFG_GREEN_FLASH] = 16'd3000;
            cfg_ms[CFG_YELLOW]      = 16'd2000;
            cfg_ms[CFG_RED]         = 16'd5000;
            cfg_ms[CFG_RED_AMBER]   = 16'd1000;
            cfg_ms[CFG_GREEN_HALF]  = 16'd500;
            cfg_ms[CFG_NIGHT_HALF]  = 16'd500;
            cur      = PH_RED;
            night    = 1'b0;
            start_us = '0;
            blink_us = '0;
            lamps    = '0;
            failures = 0;
        endfunction

        function void set_reg(tls_cfg_idx_t idx, logic [CFG_W-1:0] val);
            cfg_ms[idx] = val;
        endfunction

        function int unsigned pending();
            return expected_lights.size();
        endfunction

        // elapsed time wraps at the 48-bit time width
        function bit elapsed(tls_time_t now, tls_time_t since, logic [CFG_W-1:0] ms);
            tls_time_t       diff;
            longint unsigned limit_us;
            diff = now - since;
            limit_us = longint'(ms) * US_PER_MS;
            return longint'(diff) >= limit_us;
        endfunction

        function void enter(tls_phase_t ph, tls_time_t now);
            cur      = ph;
            start_us = now;
            blink_us = now;
            lamps    = '0;
            case (ph)
                PH_GREEN, PH_GREEN_BLINK: lamps[LAMP_G] = 1'b1;
                PH_YELLOW, PH_NIGHT:      lamps[LAMP_Y] = 1'b1;
                PH_RED:                   lamps[LAMP_R] = 1'b1;
                PH_RED_YELLOW:
                begin
                    lamps[LAMP_R] = 1'b1;
                    lamps[LAMP_Y] = 1'b1;
                end
                default:                  lamps = '0;
            endcase
        endfunction

        // time tick: phase timeouts and blinking
        function void advance(tls_time_t now);
            case (cur)
                PH_GREEN:
                    if (elapsed(now, start_us, cfg_ms[CFG_GREEN]))
                        enter(PH_GREEN_BLINK, now);
                PH_GREEN_BLINK:
                begin
                    if (elapsed(now, blink_us, cfg_ms[CFG_GREEN_HALF]))
                    begin
                        lamps[LAMP_G] = ~lamps[LAMP_G];
                        blink_us = now;
                    end
                    if (elapsed(now, start_us, cfg_ms[CFG_GREEN_FLASH]))
                        enter(PH_YELLOW, now);
                end
                PH_YELLOW:
                    if (elapsed(now, start_us, cfg_ms[CFG_YELLOW]))
                        enter(PH_RED, now);
                PH_RED:
                    if (elapsed(now, start_us, cfg_ms[CFG_RED]))
                        enter(PH_RED_YELLOW, now);
                PH_RED_YELLOW:
                    if (elapsed(now, start_us, cfg_ms[CFG_RED_AMBER]))
                        enter(PH_GREEN, now);
                PH_NIGHT:
                    if (elapsed(now, blink_us, cfg_ms[CFG_NIGHT_HALF]))
                    begin
                        lamps[LAMP_Y] = ~lamps[LAMP_Y];
                        blink_us = now;
                    end
                default: ;
            endcase
        endfunction

        // accepted event transfer: update state, queue the expected result
        function void note_event(tls_event_t ev);
            tls_result_t want;
            case (ev.kind)
                KIND_TICK:  advance(ev.now_us);
                KIND_START: enter(PH_RED, ev.now_us);
                KIND_NIGHT:
                begin
                    night = ~night;
                    enter(night ? PH_NIGHT : PH_RED, ev.now_us);
                end
                default: ;
            endcase
            want.phase        = cur;
            want.green_lamp   = lamps[LAMP_G];
            want.yellow_lamp  = lamps[LAMP_Y];
            want.red_lamp     = lamps[LAMP_R];
            want.night_active = night;
            expected_lights.push_back(want);
        endfunction

        // result transfer: compare against the oldest expectation
        function void check_result(tls_result_t got);
            tls_result_t want;
            if (expected_lights.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: phase %0d g%0b y%0b r%0b n%0b",
                             got.phase, got.green_lamp, got.yellow_lamp,
                             got.red_lamp, got.night_active);
                return;
            end
            want = expected_lights.pop_front();
            if (got.phase !== want.phase || got.green_lamp !== want.green_lamp ||
                got.yellow_lamp !== want.yellow_lamp || got.red_lamp !== want.red_lamp ||
                got.night_active !== want.night_active)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected phase %0d g%0b y%0b r%0b n%0b,",
                             want.phase, want.green_lamp, want.yellow_lamp,
                             want.red_lamp, want.night_active,
                             " got phase %0d g%0b y%0b r%0b n%0b",
                             got.phase, got.green_lamp, got.yellow_lamp,
                             got.red_lamp, got.night_active);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   sender_calm;
    bit                   sink_calm;
    tls_time_t            wall_us;
    lamp_tracker          tracker;

    tls_stream_if #(.item_t(tls_event_t))  ev_if ();
    tls_stream_if #(.item_t(tls_result_t)) res_if ();

    traffic_light_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .events    (ev_if),
        .results   (res_if)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // result side: ready with random stalls
    initial
    begin
        int stall;
        stall = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                res_if.ready = 1'b0;
                stall--;
            end
            else
            begin
                res_if.ready = 1'b1;
                stall = sink_calm ? 0 : pick_gap();
            end
        end
    end

    // result transfer check
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            tracker.check_result(res_if.payload);
    end

    // one event transfer, starting and ending at a falling edge
    task automatic send_event(input logic [1:0] kind, input tls_time_t now);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            ev_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_if.valid = 1'b1;
        ev_if.payload.kind = kind;
        ev_if.payload.now_us = now;
        do
            @(posedge clk);
        while (!ev_if.ready);
        tracker.note_event(ev_if.payload);
        @(negedge clk);
    endtask

    task automatic tick_at(input tls_time_t now);
        wall_us = now;
        send_event(KIND_TICK, now);
    endtask

    // wait until every expected result has come back
    task automatic wait_drained();
        ev_if.valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input tls_cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_reg(idx, val);
    endtask

    // all registers from one random range
    task automatic configure(input int unsigned lo, input int unsigned hi);
        for (int i = 0; i < 7; i++)
            write_reg(tls_cfg_idx_t'(i), CFG_W'($urandom_range(lo, hi)));
    endtask

    // mostly ticks on a rising clock, with restarts, night toggles, unused kinds and time jumps
    task automatic run_random_phase(input int unsigned step_max);
        int unsigned pick;
        send_event(KIND_START, wall_us);
        repeat (ITEMS_PER_PHASE - 1)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_event(KIND_START, wall_us);
            else if (pick < 8)
                send_event(KIND_NIGHT, wall_us);
            else if (pick < 10)
                send_event(KIND_UNUSED, tls_time_t'({$urandom, $urandom}));
            else
            begin
                if (pick < 12)
                    wall_us = tls_time_t'({$urandom, $urandom});
                else if (pick < 13)
                    wall_us = '1 - $urandom_range(0, step_max);
                else if (pick < 15)
                    wall_us = wall_us - $urandom_range(1, step_max + 1);
                else if (pick < 30)
                begin
                    // land on or next to a configured boundary
                    wall_us = wall_us +
                              tls_time_t'(tracker.cfg_ms[$urandom_range(0, 6)]) * US_PER_MS;
                    case ($urandom_range(0, 2))
                        0: wall_us = wall_us - 1;
                        1: wall_us = wall_us + 1;
                        default: ;
                    endcase
                end
                else
                    wall_us = wall_us + $urandom_range(0, step_max);
                send_event(KIND_TICK, wall_us);
            end
        end
    endtask

    // run limit
    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ev_if.valid = 1'b0;
        ev_if.payload = '0;
        sender_calm = 1'b0;
        sink_calm = 1'b0;
        wall_us = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // lamps stay dark after reset until a phase is entered
        tick_at(48'd0);
        send_event(KIND_UNUSED, '1);
        tick_at(48'd4_999_999);
        // full cycle with reset timings, with ticks just below and on several boundaries
        tick_at(48'd5_000_000);
        tick_at(48'd5_999_999);
        tick_at(48'd6_000_000);
        tick_at(48'd11_000_000);
        tick_at(48'd11_499_999);
        tick_at(48'd11_500_000);
        tick_at(48'd12_000_000);
        tick_at(48'd12_500_000);
        tick_at(48'd13_000_000);
        tick_at(48'd13_500_000);
        // blink and end together: yellow wins
        tick_at(48'd14_000_000);
        tick_at(48'd16_000_000);
        // night flashing, start keeps the night flag
        send_event(KIND_NIGHT, 48'd16_100_000);
        tick_at(48'd16_600_000);
        tick_at(48'd17_100_000);
        send_event(KIND_START, 48'd17_200_000);
        tick_at(48'd22_200_000);
        send_event(KIND_NIGHT, 48'd22_300_000);
        send_event(KIND_NIGHT, 48'd22_400_000);
        // time going backwards and wrapping
        tick_at(48'd1_000);
        tick_at('1);
        tick_at(48'd500_000);
        send_event(KIND_START, '1);
        wall_us = '1;

        // random phases over a spread of settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            sender_calm = (p == 2) || (p == 5);
            sink_calm = (p == 2) || (p == 6);
            case (p)
                0:
                begin
                    configure(0, 0);
                    run_random_phase(50);
                end
                1:
                begin
                    configure(65535, 65535);
                    run_random_phase(30_000_000);
                end
                6:
                begin
                    configure(0, 65535);
                    run_random_phase(40_000_000);
                end
                7:
                begin
                    configure(1, 5);
                    run_random_phase(3_000);
                end
                default:
                begin
                    configure(0, 20);
                    run_random_phase(12_000);
                end
            endcase
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (8) @(negedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
